// ----- rtl/rks_pkg.sv -----
// Shared widths and register indexes for the random k-subset selector.
// No dependencies; imported by rks_div and random_k_subset_selector.
`default_nettype none

package rks_pkg;

  localparam int unsigned WORD_W = 64;  // random word per item
  localparam int unsigned CNT_W  = 9;   // draw count, n and k
  localparam int unsigned POS_W  = 8;   // position field
  localparam int unsigned CFG_W  = 9;   // widest config register
  localparam int unsigned CIDX_W = 1;   // config register index

  typedef enum logic [CIDX_W-1:0] {
    CFG_BIT_COUNT  = 1'b0,
    CFG_ONES_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] BIT_COUNT_RST  = 9'd256;
  localparam logic [CFG_W-1:0] ONES_COUNT_RST = 9'd0;

endpackage

`default_nettype wire

// ----- rtl/random_k_subset_selector.sv -----
// Random k-subset selector: partial Fisher-Yates shuffle over a permutation RAM.
// Top level; depends on rks_pkg and rks_div.
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  ------------------------
//  item in   start_i, random_word_i, first_i            start_i & !busy_o
//  result    done_o, position_o, last_draw_o, excess_o  one-cycle strobe done_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i           cfg_we_i, no wait
//
// A drawing item runs the bit-serial remainder, then the two-port RAM read
// and two single-port writes (entry j, then entry d), before its result
// strobe. An excess item returns its result on the next cycle. Reset clears
// the written-entry flags and draw count and loads the config reset values;
// RAM contents need no reset. Results cannot be stalled; busy_o is low
// again in the cycle that carries the strobe.
`default_nettype none

module random_k_subset_selector
  import rks_pkg::*;
#(
  parameter int unsigned MAX_BITS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [WORD_W-1:0] random_word_i,
  input  wire logic              first_i,
  output logic                   done_o,
  output logic [POS_W-1:0]       position_o,
  output logic                   last_draw_o,
  output logic                   excess_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CIDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i
);

  // n never exceeds 511, so entries beyond that are never touched
  localparam int unsigned MEM_D = (MAX_BITS > 512) ? 512 : MAX_BITS;
  localparam int unsigned AW    = $clog2(MEM_D);
  localparam int unsigned NMAX  = (MAX_BITS > 511) ? 511 : MAX_BITS;
  localparam logic [CNT_W-1:0] NMAX_C = CNT_W'(NMAX);
  localparam int unsigned PW    = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_WRJ  = 4'b0100,
    S_WRD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] bit_count_q, ones_count_q;
  logic [CNT_W-1:0] draw_q, draw_d;
  logic             last_q, last_d;
  logic [MEM_D-1:0] valid_q;

  logic [CNT_W-1:0] n_val, k_val, d_eff;
  logic             accept;

  // divider
  logic             div_start, div_done;
  logic [CNT_W-1:0] div_rem;

  // RAM
  logic [AW-1:0]    mem [MEM_D];
  logic             rd_en;
  logic [AW-1:0]    rd_addr_d, rd_addr_j;
  logic [AW-1:0]    rd_d_q, rd_j_q;
  logic             vd_q, vj_q;
  logic [AW-1:0]    idx_d_q, idx_j_q;
  logic [CNT_W-1:0] j_val;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, wr_data;
  logic [AW-1:0]    at_d, at_j;
  logic [AW-1:0]    at_j_q;
  logic [PW-1:0]    pos_wide;

  // result registers
  logic             done_q, done_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             lastr_q, lastr_d;
  logic             exc_q, exc_d;

  assign accept = start_i && (state_q == S_IDLE);

  // effective n and k
  always_comb begin
    n_val = (bit_count_q > NMAX_C) ? NMAX_C : bit_count_q;
    if (n_val == '0) begin
      n_val = CNT_W'(1);
    end
    k_val = (ones_count_q > n_val) ? n_val : ones_count_q;
    d_eff = first_i ? '0 : draw_q;
  end

  assign div_start = accept && (d_eff < k_val);

  rks_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (random_word_i),
    .divisor_i  (CNT_W'(n_val - d_eff)),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign j_val     = div_rem + draw_q;
  assign rd_en     = (state_q == S_DIV) && div_done;
  assign rd_addr_d = draw_q[AW-1:0];
  assign rd_addr_j = j_val[AW-1:0];

  // unwritten entries read as their own index
  assign at_d = vd_q ? rd_d_q : idx_d_q;
  assign at_j = vj_q ? rd_j_q : idx_j_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_j_q;
    wr_data = at_d;
    unique case (state_q)
      S_WRJ: begin
        wr_en = 1'b1;
      end
      S_WRD: begin
        wr_en   = 1'b1;
        wr_addr = idx_d_q;
        wr_data = at_j_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_d_q  <= mem[rd_addr_d];
      rd_j_q  <= mem[rd_addr_j];
      vd_q    <= valid_q[rd_addr_d];
      vj_q    <= valid_q[rd_addr_j];
      idx_d_q <= rd_addr_d;
      idx_j_q <= rd_addr_j;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_q == S_WRJ) begin
      at_j_q <= at_j;
    end
  end

  assign pos_wide = PW'(at_j_q);

  always_comb begin
    state_d = state_q;
    draw_d  = draw_q;
    last_d  = last_q;
    done_d  = 1'b0;
    pos_d   = pos_q;
    lastr_d = lastr_q;
    exc_d   = exc_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          draw_d = d_eff;
          if (d_eff < k_val) begin
            last_d  = (CNT_W'(d_eff + 1'b1) == k_val);
            state_d = S_DIV;
          end else begin
            done_d  = 1'b1;
            pos_d   = '0;
            lastr_d = 1'b0;
            exc_d   = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_WRJ;
        end
      end
      S_WRJ: begin
        state_d = S_WRD;
      end
      S_WRD: begin
        draw_d  = draw_q + 1'b1;
        done_d  = 1'b1;
        pos_d   = pos_wide[POS_W-1:0];
        lastr_d = last_q;
        exc_d   = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      draw_q       <= '0;
      last_q       <= 1'b0;
      done_q       <= 1'b0;
      pos_q        <= '0;
      lastr_q      <= 1'b0;
      exc_q        <= 1'b0;
      valid_q      <= '0;
      bit_count_q  <= BIT_COUNT_RST;
      ones_count_q <= ONES_COUNT_RST;
    end else begin
      state_q <= state_d;
      draw_q  <= draw_d;
      last_q  <= last_d;
      done_q  <= done_d;
      pos_q   <= pos_d;
      lastr_q <= lastr_d;
      exc_q   <= exc_d;
      if (accept && first_i) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BIT_COUNT:  bit_count_q  <= cfg_wdata_i;
          CFG_ONES_COUNT: ones_count_q <= cfg_wdata_i;
          default:        bit_count_q  <= bit_count_q;
        endcase
      end
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign position_o  = pos_q;
  assign last_draw_o = lastr_q;
  assign excess_o    = exc_q;

endmodule

`default_nettype wire

// ----- rtl/rks_div.sv -----
// Bit-serial restoring remainder unit: 64-bit dividend, 9-bit divisor.
// One quotient bit per cycle; depends on rks_pkg.
`default_nettype none

module rks_div
  import rks_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic [CNT_W-1:0]       rem_o
);

  localparam int unsigned STEP_W = $clog2(WORD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W:0]    trial;

  assign trial = {rem_q, word_q[WORD_W-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    word_d = word_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      word_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (run_q) begin
      word_d = {word_q[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = CNT_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- tb/subset_draw_checker.sv -----
// Checker for the random k-subset selector: tracks the permutation and draw count,
// predicts each result and compares it with what the block returns.
// Depends on rks_pkg for widths and register indexes.
module subset_draw_checker
  import rks_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [WORD_W-1:0] random_word_i,
  input  wire logic              first_i,
  input  wire logic              done_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic              last_draw_i,
  input  wire logic              excess_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CIDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  output int                     mismatches_o,
  output int                     pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 256;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_draw;
    logic             excess;
  } draw_result_t;

  logic [POS_W-1:0] perm [SLOTS];
  logic [SLOTS-1:0] written;
  logic [CNT_W-1:0] draws;
  logic [CFG_W-1:0] bit_count;
  logic [CFG_W-1:0] ones_count;

  draw_result_t expected_draws [$];
  draw_result_t oldest;

  task automatic predict_draw(input logic [WORD_W-1:0] word, input logic first);
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  k;
    logic [CNT_W-1:0]  j;
    logic [WORD_W-1:0] rem;
    logic [POS_W-1:0]  at_d;
    logic [POS_W-1:0]  at_j;
    draw_result_t      res;
    if (first) begin
      written = '0;
      draws   = '0;
    end
    n = (bit_count > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : bit_count;
    if (n == '0) n = CNT_W'(1);
    k = (ones_count > n) ? n : ones_count;
    if (draws >= k) begin
      res = '{position: '0, last_draw: 1'b0, excess: 1'b1};
    end else begin
      rem  = word % WORD_W'(n - draws);
      j    = draws + rem[CNT_W-1:0];
      // unwritten entries read back as their own index
      at_d = written[draws[POS_W-1:0]] ? perm[draws[POS_W-1:0]] : draws[POS_W-1:0];
      at_j = written[j[POS_W-1:0]] ? perm[j[POS_W-1:0]] : j[POS_W-1:0];
      perm[j[POS_W-1:0]]        = at_d;
      written[j[POS_W-1:0]]     = 1'b1;
      perm[draws[POS_W-1:0]]    = at_j;
      written[draws[POS_W-1:0]] = 1'b1;
      res.position  = at_j;
      res.last_draw = (draws + CNT_W'(1)) == k;
      res.excess    = 1'b0;
      draws         = draws + CNT_W'(1);
    end
    expected_draws.push_back(res);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      written      = '0;
      draws        = '0;
      bit_count    = BIT_COUNT_RST;
      ones_count   = ONES_COUNT_RST;
      mismatches_o = 0;
      expected_draws.delete();
    end else begin
      // compare before predicting: a result and a new item may share an edge
      if (done_i) begin
        if (expected_draws.size() == 0) begin
          $display("%0t: unexpected result, position %0d last_draw %0b excess %0b",
                   $time, position_i, last_draw_i, excess_i);
          mismatches_o++;
        end else begin
          oldest = expected_draws.pop_front();
          if (position_i !== oldest.position) begin
            $display("%0t: position expected %0d got %0d", $time, oldest.position, position_i);
            mismatches_o++;
          end
          if (last_draw_i !== oldest.last_draw) begin
            $display("%0t: last_draw expected %0b got %0b", $time, oldest.last_draw,
                     last_draw_i);
            mismatches_o++;
          end
          if (excess_i !== oldest.excess) begin
            $display("%0t: excess expected %0b got %0b", $time, oldest.excess, excess_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_BIT_COUNT:  bit_count  = cfg_wdata_i;
          CFG_ONES_COUNT: ones_count = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) predict_draw(random_word_i, first_i);
    end
    pending_o = expected_draws.size();
  end

endmodule

// ----- tb/tb_random_k_subset_selector.sv -----
// Testbench top for random_k_subset_selector: clock, reset, register writes and items.
// Depends on rks_pkg, the block itself and subset_draw_checker.
module tb_random_k_subset_selector
  import rks_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned LIMIT        = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic              clk_i;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [WORD_W-1:0] random_word;
  logic              first_in;
  logic              done;
  logic [POS_W-1:0]  position;
  logic              last_draw;
  logic              excess;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;

  int          mismatches;
  int          pending;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned random_sent;
  int unsigned cur_n;
  int unsigned cur_k;

  random_k_subset_selector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .random_word_i(random_word),
    .first_i      (first_in),
    .done_o       (done),
    .position_o   (position),
    .last_draw_o  (last_draw),
    .excess_o     (excess),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  subset_draw_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .random_word_i(random_word),
    .first_i      (first_in),
    .done_i       (done),
    .position_i   (position),
    .last_draw_i  (last_draw),
    .excess_i     (excess),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("tb_random_k_subset_selector failed");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // start stays high while the block is busy; returns on the accepting edge
  task automatic send_item(input logic [WORD_W-1:0] word, input logic first);
    @(negedge clk_i);
    start       = 1'b1;
    random_word = word;
    first_in    = first;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned cycles;
    cycles = 0;
    if (idle_pct != 0) begin
      if ($urandom_range(0, 7) == 0) cycles = $urandom_range(1, 70);
      else while ($urandom_range(0, 99) < idle_pct) cycles++;
    end
    if (cycles != 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = CFG_W'(value);
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CFG_BIT_COUNT) cur_n = value;
    else cur_k = value;
  endtask

  task automatic write_both(input int unsigned n, input int unsigned k);
    write_reg(CFG_BIT_COUNT, n);
    write_reg(CFG_ONES_COUNT, k);
  endtask

  initial begin
    int unsigned pick;
    int unsigned shape;
    int unsigned len;
    int unsigned eff_n;
    int unsigned eff_k;
    int unsigned n;
    int unsigned k;
    logic        first;

    rst_n       = 1'b0;
    start       = 1'b0;
    random_word = '0;
    first_in    = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_BIT_COUNT;
    cfg_wdata   = '0;
    cycle_count = 0;
    idle_pct    = 0;
    random_sent = 0;
    cur_n       = BIT_COUNT_RST;
    cur_k       = ONES_COUNT_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // reset settings select nothing: every draw is excess
    send_item('0, 1'b1);
    send_item('1, 1'b0);
    wait_drained();
    write_both(256, 256);
    send_item('1, 1'b1);
    send_item('0, 1'b0);
    wait_drained();
    // zero size acts as one position
    write_both(0, 1);
    send_item(rand_word(), 1'b1);
    send_item(rand_word(), 1'b0);
    wait_drained();
    // both registers above the maximum saturate
    write_both(511, 511);
    send_item(64'h8000_0000_0000_0000, 1'b1);
    send_item(rand_word(), 1'b0);
    send_item(rand_word(), 1'b0);
    wait_drained();
    // more ones than positions, then one draw past the end
    write_both(5, 9);
    send_item(rand_word(), 1'b1);
    repeat (5) send_item(rand_word(), 1'b0);
    wait_drained();
    // registers rewritten part-way through a selection
    write_both(12, 6);
    send_item(rand_word(), 1'b1);
    repeat (2) send_item(rand_word(), 1'b0);
    wait_drained();
    write_reg(CFG_ONES_COUNT, 2);
    send_item(rand_word(), 1'b0);
    wait_drained();
    write_both(4, 8);
    send_item(rand_word(), 1'b0);
    send_item(rand_word(), 1'b0);

    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          n = $urandom_range(257, 511);
          k = $urandom_range(0, 511);
        end
        1: begin
          n = $urandom_range(0, 4);
          k = $urandom_range(0, 6);
        end
        2: begin
          n = 256;
          k = $urandom_range(200, 256);
        end
        default: begin
          n = $urandom_range(1, 64);
          k = $urandom_range(0, n);
        end
      endcase
      // sometimes only k moves, leaving the running selection in place
      if ($urandom_range(0, 3) == 0) write_reg(CFG_ONES_COUNT, k);
      else write_both(n, k);
      eff_n = (cur_n > 256) ? 256 : ((cur_n == 0) ? 1 : cur_n);
      eff_k = (cur_k > eff_n) ? eff_n : cur_k;
      repeat ($urandom_range(1, 3)) begin
        shape = $urandom_range(0, 9);
        if (shape < 7) len = eff_k + $urandom_range(0, 2);
        else len = $urandom_range(1, 20);
        if (len == 0) len = 1;
        for (int unsigned i = 0; i < len; i++) begin
          idle_pct = (random_sent < RANDOM_ITEMS / 3) ? 28 :
                     (random_sent < 2 * RANDOM_ITEMS / 3) ? 60 : 0;
          if (shape < 7) first = (i == 0);
          else if (shape == 7) first = 1'b0;
          else first = ($urandom_range(0, 3) == 0);
          idle_gap();
          send_item(rand_word(), first);
          random_sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_random_k_subset_selector passed");
    end else begin
      $display("tb_random_k_subset_selector failed");
    end
    $finish;
  end

endmodule
